FILE: design/blvs_pkg.sv
// Shared types, codes and helper functions for the battery level supervisor.
// No dependencies; used by every other file of the block.

package blvs_pkg;

    localparam int VoltW  = 16;
    localparam int RunW   = 8;
    localparam int LevelW = 2;
    localparam int EventW = 3;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    // battery levels
    localparam logic [LevelW-1:0] LVL_NORMAL = 2'd0;
    localparam logic [LevelW-1:0] LVL_LOW    = 2'd1;
    localparam logic [LevelW-1:0] LVL_ULTRA  = 2'd2;

    // transition events
    localparam logic [EventW-1:0] EVT_NONE       = 3'd0;
    localparam logic [EventW-1:0] EVT_ENTER_LOW  = 3'd1;
    localparam logic [EventW-1:0] EVT_ENTER_ULTRA = 3'd2;
    localparam logic [EventW-1:0] EVT_BACK_NORMAL = 3'd3;
    localparam logic [EventW-1:0] EVT_BACK_LOW   = 3'd4;

    // register indexes (word address = paddr[3:2])
    localparam logic [1:0] REG_LOW_LEVEL   = 2'd0;
    localparam logic [1:0] REG_ULTRA_LEVEL = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE    = 2'd2;

    localparam logic [RunW-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [RunW-1:0] RUN_MAX        = 8'hFF;

    typedef struct packed {
        logic [VoltW-1:0] low_level;
        logic [VoltW-1:0] ultra_low_level;
        logic [RunW-1:0]  debounce_count;
    } t_cfg;

    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [EventW-1:0] event_res;
        logic              low_power_indicator;
        logic              skipped;
    } t_result;

    typedef struct packed {
        logic [RunW-1:0] run;
        logic            hit;
    } t_run;

    // One debounce step: count a qualifying sample (saturating), report and
    // clear once the run reaches the count; a miss clears the run.
    function automatic t_run run_step(input logic [RunW-1:0] run,
                                      input logic qualifies,
                                      input logic [RunW-1:0] count);
        t_run            res;
        logic [RunW-1:0] inc;
        inc = (run < RUN_MAX) ? run + 8'd1 : run;
        res.run = '0;
        res.hit = 1'b0;
        if (qualifies) begin
            if (inc >= count) begin
                res.hit = 1'b1;
            end else begin
                res.run = inc;
            end
        end
        return res;
    endfunction

endpackage

FILE: design/battery_level_supervisor_top.sv
// Top level of the battery level supervisor: input register, level machine,
// result register and configuration port. Depends on blvs_pkg,
// blvs_cfg_regs and blvs_level_fsm.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one sampling tick per item:
//   i_voltage and i_transmit_busy. Output channel (o_valid / i_stall)
//   returns exactly one result item per tick: level, event code,
//   low-power indicator and skipped flag. A busy tick changes no state.
//   Pipeline: two register stages, input register then result register.
//   Throughput: one item per cycle unless i_stall holds a full result
//   register; the level machine compares and updates its counters
//   between the two registers.
//   Stall: when i_stall holds a full result register, the input register
//   keeps its item and o_stall rises; nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): level normal, both runs zero,
//   thresholds zero, debounce count three, both channels empty.
//   Configuration: APB-style, registers at byte addresses 0 (low level),
//   4 (ultra-low level) and 8 (debounce count); write only while idle.

module battery_level_supervisor_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [blvs_pkg::VoltW-1:0] i_voltage,
    input  logic                       i_transmit_busy,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [blvs_pkg::LevelW-1:0] o_level,
    output logic [blvs_pkg::EventW-1:0] o_event_res,
    output logic                       o_low_power_indicator,
    output logic                       o_skipped,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blvs_pkg::AddrW-1:0] paddr,
    input  logic [blvs_pkg::DataW-1:0] pwdata,
    output logic [blvs_pkg::DataW-1:0] prdata,
    output logic                       pready
);

    blvs_pkg::t_cfg    cfg;
    blvs_pkg::t_result res;
    blvs_pkg::t_result r_out;

    logic                       r_in_valid;
    logic [blvs_pkg::VoltW-1:0] r_in_voltage;
    logic                       r_in_busy;
    logic                       r_out_valid;
    logic                       advance;

    // Advance the held item whenever the result register is empty or drains.
    assign advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & ~advance;

    blvs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: load a new item whenever the stage is not held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_voltage <= i_voltage;
            r_in_busy    <= i_transmit_busy;
        end
    end

    // The machine commits its state only on the cycle its item advances.
    blvs_level_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_voltage (r_in_voltage),
        .i_busy    (r_in_busy),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    // Result register: fill on advance, empty when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_level               = r_out.level;
    assign o_event_res           = r_out.event_res;
    assign o_low_power_indicator = r_out.low_power_indicator;
    assign o_skipped             = r_out.skipped;

endmodule

FILE: design/blvs_cfg_regs.sv
// Configuration register file with its APB-style access port.
// Depends on blvs_pkg.

module blvs_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blvs_pkg::AddrW-1:0] paddr,
    input  logic [blvs_pkg::DataW-1:0] pwdata,
    output logic [blvs_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output blvs_pkg::t_cfg             o_cfg
);

    blvs_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_level       <= '0;
            r_cfg.ultra_low_level <= '0;
            r_cfg.debounce_count  <= blvs_pkg::DEBOUNCE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                blvs_pkg::REG_LOW_LEVEL: begin
                    r_cfg.low_level <= pwdata[blvs_pkg::VoltW-1:0];
                end
                blvs_pkg::REG_ULTRA_LEVEL: begin
                    r_cfg.ultra_low_level <= pwdata[blvs_pkg::VoltW-1:0];
                end
                blvs_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce_count <= pwdata[blvs_pkg::RunW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            blvs_pkg::REG_LOW_LEVEL:   prdata[blvs_pkg::VoltW-1:0] = r_cfg.low_level;
            blvs_pkg::REG_ULTRA_LEVEL: prdata[blvs_pkg::VoltW-1:0] = r_cfg.ultra_low_level;
            blvs_pkg::REG_DEBOUNCE:    prdata[blvs_pkg::RunW-1:0]  = r_cfg.debounce_count;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/blvs_level_fsm.sv
// Level state machine with the below/above debounce counters.
// Depends on blvs_pkg; result is combinational from the current sample.

module blvs_level_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [blvs_pkg::VoltW-1:0] i_voltage,
    input  logic                       i_busy,
    input  blvs_pkg::t_cfg             i_cfg,
    output blvs_pkg::t_result          o_res
);

    logic [blvs_pkg::LevelW-1:0] r_level, n_level;
    logic [blvs_pkg::RunW-1:0]   r_below, n_below;
    logic [blvs_pkg::RunW-1:0]   r_above, n_above;
    logic [blvs_pkg::EventW-1:0] evt;

    logic below_qual, above_qual;
    blvs_pkg::t_run below_res, above_res;

    // thresholds depend on the current level
    always_comb begin
        below_qual = 1'b0;
        above_qual = 1'b0;
        case (r_level)
            blvs_pkg::LVL_NORMAL: begin
                below_qual = i_voltage < i_cfg.low_level;
            end
            blvs_pkg::LVL_LOW: begin
                below_qual = i_voltage < i_cfg.ultra_low_level;
                above_qual = i_voltage >= i_cfg.low_level;
            end
            blvs_pkg::LVL_ULTRA: begin
                above_qual = i_voltage >= i_cfg.ultra_low_level;
            end
            default: ;
        endcase
    end

    assign below_res = blvs_pkg::run_step(r_below, below_qual, i_cfg.debounce_count);
    assign above_res = blvs_pkg::run_step(r_above, above_qual, i_cfg.debounce_count);

    always_comb begin
        n_level = r_level;
        n_below = r_below;
        n_above = r_above;
        evt     = blvs_pkg::EVT_NONE;
        if (!i_busy) begin
            case (r_level)
                blvs_pkg::LVL_NORMAL: begin
                    n_below = below_res.run;
                    if (below_res.hit) begin
                        n_level = blvs_pkg::LVL_LOW;
                        evt     = blvs_pkg::EVT_ENTER_LOW;
                    end
                end
                blvs_pkg::LVL_LOW: begin
                    n_below = below_res.run;
                    n_above = above_res.run;
                    // recovery is checked first and wins on a double hit
                    if (above_res.hit) begin
                        n_level = blvs_pkg::LVL_NORMAL;
                        evt     = blvs_pkg::EVT_BACK_NORMAL;
                    end else if (below_res.hit) begin
                        n_level = blvs_pkg::LVL_ULTRA;
                        evt     = blvs_pkg::EVT_ENTER_ULTRA;
                    end
                end
                blvs_pkg::LVL_ULTRA: begin
                    n_above = above_res.run;
                    if (above_res.hit) begin
                        n_level = blvs_pkg::LVL_LOW;
                        evt     = blvs_pkg::EVT_BACK_LOW;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= blvs_pkg::LVL_NORMAL;
            r_below <= '0;
            r_above <= '0;
        end else if (i_step) begin
            r_level <= n_level;
            r_below <= n_below;
            r_above <= n_above;
        end
    end

    assign o_res.level               = n_level;
    assign o_res.event_res           = evt;
    assign o_res.low_power_indicator = (n_level == blvs_pkg::LVL_LOW) ||
                                       (n_level == blvs_pkg::LVL_ULTRA);
    assign o_res.skipped             = i_busy;

endmodule

FILE: tb/tb_battery_level_supervisor_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for battery_level_supervisor_top: predicts the level machine
// per accepted tick and checks every status item; uses blvs_pkg and the block's RTL.

module tb_battery_level_supervisor_top;

    localparam int VoltW  = blvs_pkg::VoltW;
    localparam int RunW   = blvs_pkg::RunW;
    localparam int LevelW = blvs_pkg::LevelW;
    localparam int EventW = blvs_pkg::EventW;
    localparam int AddrW  = blvs_pkg::AddrW;
    localparam int DataW  = blvs_pkg::DataW;

    // cycles without any accepted item or register access before the run is declared hung
    localparam int IdleLimit = 4000;
    // word index that maps to no register; writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                o_stall;
    logic [VoltW-1:0]    i_voltage       = '0;
    logic                i_transmit_busy = 1'b0;
    logic                o_valid;
    logic                i_stall         = 1'b0;
    logic [LevelW-1:0]   o_level;
    logic [EventW-1:0]   o_event_res;
    logic                o_low_power_indicator;
    logic                o_skipped;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [AddrW-1:0]    paddr           = '0;
    logic [DataW-1:0]    pwdata          = '0;
    logic [DataW-1:0]    prdata;
    logic                pready;

    battery_level_supervisor_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_voltage             (i_voltage),
        .i_transmit_busy       (i_transmit_busy),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_level               (o_level),
        .o_event_res           (o_event_res),
        .o_low_power_indicator (o_low_power_indicator),
        .o_skipped             (o_skipped),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted supervisor state: thresholds, level and both debounce runs
    // ------------------------------------------------------------------
    blvs_pkg::t_cfg    model_cfg;
    logic [LevelW-1:0] model_level;
    logic [RunW-1:0]   below_cnt;
    logic [RunW-1:0]   above_cnt;

    // status items predicted for accepted ticks, oldest first
    blvs_pkg::t_result pending_status[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // sender burst control
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // receiver hold-off request: bump hold_token after setting hold_len
    int hold_len   = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_phase     = 0;

    // Advance one debounce run; returns {hit, new run}. A miss clears the run,
    // a hit clears it too, and the count saturates at the top.
    function automatic logic [RunW:0] count_run(input logic [RunW-1:0] run,
                                                input bit qual,
                                                input logic [RunW-1:0] need);
        logic [RunW-1:0] inc;
        if (!qual) return '0;
        inc = (run < blvs_pkg::RUN_MAX) ? run + 1'b1 : run;
        if (inc >= need) return {1'b1, {RunW{1'b0}}};
        return {1'b0, inc};
    endfunction

    // Apply one tick to the predicted state and return the status it causes.
    function automatic blvs_pkg::t_result supervise_tick(input logic [VoltW-1:0] volt,
                                                         input logic busy);
        blvs_pkg::t_result res;
        logic [RunW:0]     r;
        logic [EventW-1:0] ev_code;
        ev_code = blvs_pkg::EVT_NONE;
        if (!busy) begin
            case (model_level)
                blvs_pkg::LVL_NORMAL: begin
                    r = count_run(below_cnt, volt < model_cfg.low_level,
                                  model_cfg.debounce_count);
                    below_cnt = r[RunW-1:0];
                    if (r[RunW]) begin
                        model_level = blvs_pkg::LVL_LOW;
                        ev_code     = blvs_pkg::EVT_ENTER_LOW;
                    end
                end
                blvs_pkg::LVL_LOW: begin
                    r = count_run(below_cnt, volt < model_cfg.ultra_low_level,
                                  model_cfg.debounce_count);
                    below_cnt = r[RunW-1:0];
                    if (r[RunW]) begin
                        model_level = blvs_pkg::LVL_ULTRA;
                        ev_code     = blvs_pkg::EVT_ENTER_ULTRA;
                    end
                    // checked second, so a recovery on the same tick wins
                    r = count_run(above_cnt, volt >= model_cfg.low_level,
                                  model_cfg.debounce_count);
                    above_cnt = r[RunW-1:0];
                    if (r[RunW]) begin
                        model_level = blvs_pkg::LVL_NORMAL;
                        ev_code     = blvs_pkg::EVT_BACK_NORMAL;
                    end
                end
                blvs_pkg::LVL_ULTRA: begin
                    r = count_run(above_cnt, volt >= model_cfg.ultra_low_level,
                                  model_cfg.debounce_count);
                    above_cnt = r[RunW-1:0];
                    if (r[RunW]) begin
                        model_level = blvs_pkg::LVL_LOW;
                        ev_code     = blvs_pkg::EVT_BACK_LOW;
                    end
                end
                default: ;
            endcase
        end
        res.level               = model_level;
        res.event_res           = ev_code;
        res.low_power_indicator = (model_level == blvs_pkg::LVL_LOW) ||
                                  (model_level == blvs_pkg::LVL_ULTRA);
        res.skipped             = busy;
        return res;
    endfunction

    // Pick a voltage just at or inside one side of a threshold.
    function automatic logic [VoltW-1:0] pick_near(input logic [VoltW-1:0] thr, input bit below);
        if (below) begin
            if (thr == '0) return VoltW'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) != 0) return thr - 1'b1;
            return VoltW'($urandom_range(0, int'(thr) - 1));
        end
        if ($urandom_range(0, 1) != 0) return thr;
        return VoltW'($urandom_range(int'(thr), 65535));
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input channel: offer one tick, hold it until accepted, then predict
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [VoltW-1:0] volt, input logic busy);
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_voltage       = volt;
        i_transmit_busy = busy;
        do @(posedge i_clk); while (o_stall);
        pending_status.push_back(supervise_tick(volt, busy));
    endtask

    // Send a tick as part of a burst; at the end of a burst, with gaps on, drop valid for a random gap.
    task automatic send_item(input logic [VoltW-1:0] volt, input logic busy);
        int gap;
        send_tick(volt, busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            if (gaps_on) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    endtask

    // Stop offering and wait until every predicted status has come back.
    task automatic drain_results;
        @(negedge i_clk);
        i_valid    = 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            blvs_pkg::REG_LOW_LEVEL:   model_cfg.low_level       = data[VoltW-1:0];
            blvs_pkg::REG_ULTRA_LEVEL: model_cfg.ultra_low_level = data[VoltW-1:0];
            blvs_pkg::REG_DEBOUNCE:    model_cfg.debounce_count  = data[RunW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [DataW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_regs;
        logic [DataW-1:0] rd;
        apb_read(blvs_pkg::REG_LOW_LEVEL, rd);
        compare_field("low_level register", model_cfg.low_level, rd[VoltW-1:0]);
        apb_read(blvs_pkg::REG_ULTRA_LEVEL, rd);
        compare_field("ultra_low_level register", model_cfg.ultra_low_level, rd[VoltW-1:0]);
        apb_read(blvs_pkg::REG_DEBOUNCE, rd);
        compare_field("debounce_count register", model_cfg.debounce_count, rd[RunW-1:0]);
    endtask

    // Drain, write all three registers (junk in the unused upper bits), read back.
    task automatic configure(input logic [VoltW-1:0] lo, input logic [VoltW-1:0] ul,
                             input logic [RunW-1:0] deb);
        drain_results;
        apb_write(blvs_pkg::REG_LOW_LEVEL,   ($urandom() << VoltW) | lo);
        apb_write(blvs_pkg::REG_ULTRA_LEVEL, ($urandom() << VoltW) | ul);
        apb_write(blvs_pkg::REG_DEBOUNCE,    ($urandom() << RunW) | deb);
        check_regs;
    endtask

    // ------------------------------------------------------------------
    // Status checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        blvs_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status item: expected none, actual level %0d event %0d",
                         $time, o_level, o_event_res);
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                compare_field("level", want.level, o_level);
                compare_field("event_res", want.event_res, o_event_res);
                compare_field("low_power_indicator", want.low_power_indicator,
                              o_low_power_indicator);
                compare_field("skipped", want.skipped, o_skipped);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on one of four randomly chosen patterns,
    // or hold off completely while a hold-off request is running
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: i_stall = 1'b0;
                1: i_stall = ($urandom_range(0, 99) < 30);
                2: i_stall = ((rx_phase % 5) >= 3);
                default: i_stall = ($urandom_range(0, 99) < 70);
            endcase
        end
        rx_phase++;
    end

    // Watchdog: any accepted item or register access counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Check reset register values; with a zero low level nothing can ever go low.
    task automatic test_reset_defaults;
        check_regs;
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'hFFFF, 1'b0);
    endtask

    // Walk normal -> low -> ultra-low -> low -> normal, with busy ticks inside runs
    // and samples exactly at a threshold.
    task automatic test_level_walk;
        configure(16'd1000, 16'd500, 8'd3);
        send_item(16'd999, 1'b0);
        send_item(16'd999, 1'b0);
        send_item(16'd0, 1'b1);      // busy: skipped, run survives
        send_item(16'd999, 1'b0);    // enters low
        send_item(16'd1000, 1'b0);
        send_item(16'd499, 1'b0);
        send_item(16'd499, 1'b0);
        send_item(16'd499, 1'b0);    // enters ultra-low
        send_item(16'd500, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'd500, 1'b0);    // back to low
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);   // back to normal
        send_item(16'd0, 1'b0);
        send_item(16'hFFFF, 1'b0);   // miss clears the below run
    endtask

    // Ultra level above low level: one sample can finish both runs at once in low,
    // and recovery must win. Then a debounce count of zero.
    task automatic test_dual_transition;
        configure(16'd500, 16'd1000, 8'd2);
        send_item(16'd100, 1'b0);
        send_item(16'd100, 1'b0);    // enters low
        send_item(16'd700, 1'b0);
        send_item(16'd700, 1'b0);    // both runs hit: back to normal
        configure(16'd500, 16'd1000, 8'd0);
        send_item(16'd100, 1'b0);    // first qualifying sample is enough
        send_item(16'd700, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd50, 1'b0);
        send_item(16'd2000, 1'b0);
    endtask

    // A write to the unused word must leave every register as it was.
    task automatic test_spare_register;
        drain_results;
        apb_write(REG_SPARE, $urandom());
        check_regs;
    endtask

    // Hold the receiver off long enough to fill the block, keep offering items
    // without gaps, then pause the sender until all status has come back.
    task automatic test_backpressure;
        configure(16'd30000, 16'd10000, 8'd2);
        gaps_on    = 1'b0;
        hold_len   = 200;
        hold_token = hold_token + 1;
        repeat (40) send_item(VoltW'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
        drain_results;
        gaps_on = 1'b1;
    endtask

    // Mostly runs of samples on one side of a threshold with lengths around the
    // debounce count, plus random noise; busy ticks sprinkled in.
    task automatic run_phase(input int n_items);
        int               done;
        int               deb;
        int               run_len;
        bit               below;
        logic [VoltW-1:0] thr;
        done = 0;
        deb  = int'(model_cfg.debounce_count);
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(VoltW'($urandom_range(0, 65535)), 1'b0);
                done++;
            end else begin
                thr   = ($urandom_range(0, 1) != 0) ? model_cfg.low_level
                                                    : model_cfg.ultra_low_level;
                below = 1'($urandom_range(0, 1));
                if (deb <= 1) begin
                    run_len = $urandom_range(1, 3);
                end else if ($urandom_range(0, 2) != 0) begin
                    run_len = deb - 1 + $urandom_range(0, 2);
                end else begin
                    run_len = $urandom_range(1, 2 * deb);
                end
                repeat (run_len) begin
                    if ($urandom_range(0, 99) < 8)
                        send_item(VoltW'($urandom_range(0, 65535)), 1'b1);
                    send_item(pick_near(thr, below), 1'b0);
                    done++;
                end
            end
        end
    endtask

    task automatic test_random_phases;
        logic [VoltW-1:0] lo;
        logic [VoltW-1:0] ul;
        // top thresholds: only 65535 counts as recovered
        configure(16'hFFFF, 16'hFFFF, 8'd1);
        run_phase(80);
        // zero thresholds: the level can never leave normal
        configure(16'h0000, 16'h0000, 8'd2);
        run_phase(60);
        repeat (5) begin
            lo = VoltW'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
                ul = VoltW'($urandom_range(int'(lo), 65535));
            else
                ul = VoltW'($urandom_range(0, int'(lo)));
            configure(lo, ul, RunW'($urandom_range(1, 8)));
            gaps_on = ($urandom_range(0, 3) != 0);
            run_phase(80);
        end
        // longest debounce count
        gaps_on = 1'b1;
        configure(16'd40000, 16'd20000, blvs_pkg::RUN_MAX);
        run_phase(520);
    endtask

    initial begin
        model_cfg.low_level       = '0;
        model_cfg.ultra_low_level = '0;
        model_cfg.debounce_count  = blvs_pkg::DEBOUNCE_RESET;
        model_level               = blvs_pkg::LVL_NORMAL;
        below_cnt                 = '0;
        above_cnt                 = '0;

        // hold reset, then release it on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults;
        test_level_walk;
        test_dual_transition;
        test_spare_register;
        test_backpressure;
        test_random_phases;

        drain_results;
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/blvs_pkg.sv
design/blvs_cfg_regs.sv
design/blvs_level_fsm.sv
design/battery_level_supervisor_top.sv
tb/tb_battery_level_supervisor_top.sv
